### rtl/wfc_pkg.sv
// Shared constants, codes and interface types for the wall follow controller.
`default_nettype none
package wfc_pkg;

    localparam int WINDOW = 5;
    localparam int NSENS  = 5;

    localparam int SMP_W  = 12;
    localparam int THR_W  = 12;
    localparam int SCALE_W = 4;
    localparam int LIM_W  = 10;
    localparam int OUT_W  = 11;
    localparam int MODE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int SUM_W  = $clog2(WINDOW * 4095 + 1);
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WARM_TICKS = 2 * WINDOW;
    localparam int WARM_W = $clog2(WARM_TICKS + 1);
    localparam int SPD_W  = 8;
    localparam int SCL_W  = 12;

    localparam int SENS_RFRONT = 0;
    localparam int SENS_RDIAG  = 1;
    localparam int SENS_LSIDE  = 2;
    localparam int SENS_LDIAG  = 3;
    localparam int SENS_LFRONT = 4;

    localparam logic [MODE_W-1:0] MODE_OK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FAR    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RTURN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LSTART = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LTURN  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_WALL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_OK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLLISION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd6;

    localparam logic signed [SPD_W-1:0] SPD_ZERO = 8'sd0;
    localparam logic signed [SPD_W-1:0] SPD_FULL = 8'sd100;
    localparam logic signed [SPD_W-1:0] SPD_BACK = -8'sd100;
    localparam logic signed [SPD_W-1:0] SPD_TURN = 8'sd40;
    localparam logic signed [SPD_W-1:0] SPD_SLOW = 8'sd20;

    typedef struct packed {
        logic capture;
        logic update;
        logic decide;
        logic scale;
        logic finish;
    } wfc_cmd_t;

    typedef struct packed {
        logic warming;
    } wfc_status_t;

endpackage
`default_nettype wire

### rtl/wall_follow_controller_core.sv
// One beat at a time: the sequencer takes an input beat, then walks update, decide, scale and
// load (only update and load during warmup); load waits while a held result has not been
// taken.
// The result register holds a finished beat while the next input beat is taken.
// Reset (aresetn, synchronous, active low) clears the filter windows and sums,
// restores register defaults, and restarts the 2*WINDOW beat warmup in ok mode.
`default_nettype none
module wall_follow_controller_core
    import wfc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [SMP_W-1:0]      s_right_front_sample,
    input  wire logic [SMP_W-1:0]      s_right_diag_sample,
    input  wire logic [SMP_W-1:0]      s_left_side_sample,
    input  wire logic [SMP_W-1:0]      s_left_diag_sample,
    input  wire logic [SMP_W-1:0]      s_left_front_sample,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_drive_valid,
    output logic signed [OUT_W-1:0]    m_left_speed,
    output logic signed [OUT_W-1:0]    m_right_speed,
    output logic                       m_speed_warning,
    output logic [MODE_W-1:0]          m_next_mode
);

    wfc_cmd_t    cmd;
    wfc_status_t status;
    logic [SMP_W-1:0] in_sample [NSENS];

    assign in_sample[SENS_RFRONT] = s_right_front_sample;
    assign in_sample[SENS_RDIAG]  = s_right_diag_sample;
    assign in_sample[SENS_LSIDE]  = s_left_side_sample;
    assign in_sample[SENS_LDIAG]  = s_left_diag_sample;
    assign in_sample[SENS_LFRONT] = s_left_front_sample;

    wfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wfc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_sample     (in_sample),
        .drive_valid   (m_drive_valid),
        .left_speed    (m_left_speed),
        .right_speed   (m_right_speed),
        .speed_warning (m_speed_warning),
        .next_mode     (m_next_mode)
    );

endmodule
`default_nettype wire

### rtl/wfc_ctrl.sv
// Sequencer for one sensor beat: window update, mode decision and scaling (both skipped during warmup), result load.
`default_nettype none
module wfc_ctrl
    import wfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire wfc_status_t status,
    output wfc_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_SCALE  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   load;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign load    = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd         = '0;
        cmd.capture = s_ready && s_valid;
        cmd.update  = (state_reg == ST_UPDATE);
        cmd.decide  = (state_reg == ST_DECIDE);
        cmd.scale   = (state_reg == ST_SCALE);
        cmd.finish  = load;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = status.warming ? ST_FINISH : ST_DECIDE;
            end
            ST_DECIDE: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_FINISH;
            ST_FINISH: begin
                if (load) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

### rtl/wfc_datapath.sv
// Filter windows, running sums, follow mode logic, speed scaling and clamping.
`default_nettype none
module wfc_datapath
    import wfc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire wfc_cmd_t                cmd,
    output wfc_status_t                  status,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [SMP_W-1:0]        in_sample [NSENS],
    output logic                         drive_valid,
    output logic signed [OUT_W-1:0]      left_speed,
    output logic signed [OUT_W-1:0]      right_speed,
    output logic                         speed_warning,
    output logic [MODE_W-1:0]            next_mode
);

    logic [THR_W-1:0]   thr_no_wall_reg, thr_far_ok_reg, thr_far_reg;
    logic [THR_W-1:0]   thr_close_reg, thr_collision_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [LIM_W-1:0]   limit_reg;

    logic [SMP_W-1:0]   smp_reg [NSENS];
    logic [SMP_W-1:0]   win_reg [NSENS][WINDOW];
    logic [SUM_W-1:0]   sum_reg [NSENS];
    logic [SUM_W-1:0]   sum_next [NSENS];
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [WARM_W-1:0]  warm_cnt_reg;
    logic               warm_reg;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic               drv_reg, drv_next;
    logic signed [SPD_W-1:0] l_reg, r_reg, l_next, r_next;
    logic signed [SCL_W-1:0] ls_reg, rs_reg;

    logic [SUM_W-1:0]   nw_lim, fok_lim, far_lim, cls_lim, col_lim;
    logic [SUM_W-1:0]   s_rf, s_rd, s_ls, s_ld, s_lf;

    logic               out_drive_reg, out_warn_reg;
    logic signed [OUT_W-1:0] out_l_reg, out_r_reg;
    logic [MODE_W-1:0]  out_mode_reg;

    logic [SCL_W-1:0]   al, ar;
    logic               over;
    logic signed [OUT_W-1:0] lim_pos, lim_neg, l_fin, r_fin;

    assign status.warming = (warm_cnt_reg < WARM_W'(WARM_TICKS));

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_no_wall_reg   <= THR_W'(150);
            thr_far_ok_reg    <= THR_W'(200);
            thr_far_reg       <= THR_W'(250);
            thr_close_reg     <= THR_W'(500);
            thr_collision_reg <= THR_W'(1000);
            scale_reg         <= SCALE_W'(1);
            limit_reg         <= LIM_W'(1000);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_NO_WALL:   thr_no_wall_reg   <= cfg_data[THR_W-1:0];
                CFG_FAR_OK:    thr_far_ok_reg    <= cfg_data[THR_W-1:0];
                CFG_FAR:       thr_far_reg       <= cfg_data[THR_W-1:0];
                CFG_CLOSE:     thr_close_reg     <= cfg_data[THR_W-1:0];
                CFG_COLLISION: thr_collision_reg <= cfg_data[THR_W-1:0];
                CFG_SCALE:     scale_reg         <= cfg_data[SCALE_W-1:0];
                CFG_LIMIT:     limit_reg         <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int s = 0; s < NSENS; s++) smp_reg[s] <= in_sample[s];
        end
    end

    // window update with running sums
    always_comb begin
        for (int s = 0; s < NSENS; s++) begin
            sum_next[s] = sum_reg[s] - SUM_W'(win_reg[s][ptr_reg]) + SUM_W'(smp_reg[s]);
        end
        ptr_next = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + PTR_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NSENS; s++) begin
                sum_reg[s] <= '0;
                for (int i = 0; i < WINDOW; i++) win_reg[s][i] <= '0;
            end
            ptr_reg      <= '0;
            warm_cnt_reg <= '0;
            warm_reg     <= 1'b1;
        end else if (cmd.update) begin
            for (int s = 0; s < NSENS; s++) begin
                sum_reg[s]               <= sum_next[s];
                win_reg[s][ptr_reg]      <= smp_reg[s];
            end
            ptr_reg  <= ptr_next;
            warm_reg <= status.warming;
            if (status.warming) warm_cnt_reg <= warm_cnt_reg + WARM_W'(1);
        end
    end

    // mode decision
    assign nw_lim  = SUM_W'(thr_no_wall_reg)   * SUM_W'(WINDOW);
    assign fok_lim = SUM_W'(thr_far_ok_reg)    * SUM_W'(WINDOW);
    assign far_lim = SUM_W'(thr_far_reg)       * SUM_W'(WINDOW);
    assign cls_lim = SUM_W'(thr_close_reg)     * SUM_W'(WINDOW);
    assign col_lim = SUM_W'(thr_collision_reg) * SUM_W'(WINDOW);
    assign s_rf = sum_reg[SENS_RFRONT];
    assign s_rd = sum_reg[SENS_RDIAG];
    assign s_ls = sum_reg[SENS_LSIDE];
    assign s_ld = sum_reg[SENS_LDIAG];
    assign s_lf = sum_reg[SENS_LFRONT];

    always_comb begin
        mode_next = mode_reg;
        drv_next  = 1'b1;
        l_next    = SPD_ZERO;
        r_next    = SPD_ZERO;
        case (mode_reg)
            MODE_OK: begin
                drv_next = 1'b0;
                if (s_rf > col_lim || s_lf > col_lim || s_rd > col_lim || s_ld > col_lim) begin
                    mode_next = MODE_RTURN;
                end else if (s_ld > cls_lim) begin
                    mode_next = MODE_CLOSE;
                end else if (s_ld < far_lim) begin
                    mode_next = (s_ld < nw_lim) ? MODE_LSTART : MODE_FAR;
                end else begin
                    drv_next = 1'b1;
                    l_next   = SPD_FULL;
                    r_next   = SPD_FULL;
                end
            end
            MODE_FAR: begin
                l_next = SPD_SLOW;
                r_next = SPD_FULL;
                if (s_ld > fok_lim) begin
                    mode_next = MODE_OK;
                end else if (s_ld < nw_lim) begin
                    mode_next = MODE_LSTART;
                end
            end
            MODE_CLOSE: begin
                l_next = SPD_FULL;
                r_next = SPD_SLOW;
                if (s_ld < cls_lim) mode_next = MODE_OK;
            end
            MODE_LSTART: begin
                l_next = SPD_FULL;
                r_next = SPD_FULL;
                if (s_ls < nw_lim) mode_next = MODE_LTURN;
            end
            MODE_LTURN: begin
                l_next = SPD_TURN;
                r_next = SPD_FULL;
                if (s_ld > far_lim) mode_next = MODE_OK;
            end
            MODE_RTURN: begin
                l_next = SPD_FULL;
                r_next = SPD_BACK;
                if (s_lf < nw_lim && s_rf < nw_lim) mode_next = MODE_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_OK;
        end else if (cmd.decide) begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            drv_reg <= drv_next;
            l_reg   <= l_next;
            r_reg   <= r_next;
        end
        if (cmd.scale) begin
            ls_reg <= SCL_W'(l_reg) * $signed(SCL_W'({1'b0, scale_reg}));
            rs_reg <= SCL_W'(r_reg) * $signed(SCL_W'({1'b0, scale_reg}));
        end
    end

    // saturation
    always_comb begin
        al      = ls_reg[SCL_W-1] ? SCL_W'(-ls_reg) : SCL_W'(ls_reg);
        ar      = rs_reg[SCL_W-1] ? SCL_W'(-rs_reg) : SCL_W'(rs_reg);
        over    = (al > SCL_W'(limit_reg)) || (ar > SCL_W'(limit_reg));
        lim_pos = $signed(OUT_W'(limit_reg));
        lim_neg = -lim_pos;
        if (over) begin
            l_fin = l_reg[SPD_W-1] ? lim_neg : lim_pos;
            r_fin = r_reg[SPD_W-1] ? lim_neg : lim_pos;
        end else begin
            l_fin = ls_reg[OUT_W-1:0];
            r_fin = rs_reg[OUT_W-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_mode_reg <= mode_reg;
            if (warm_reg || !drv_reg) begin
                out_drive_reg <= 1'b0;
                out_warn_reg  <= 1'b0;
                out_l_reg     <= '0;
                out_r_reg     <= '0;
            end else begin
                out_drive_reg <= 1'b1;
                out_warn_reg  <= over;
                out_l_reg     <= l_fin;
                out_r_reg     <= r_fin;
            end
        end
    end

    assign drive_valid   = out_drive_reg;
    assign left_speed    = out_l_reg;
    assign right_speed   = out_r_reg;
    assign speed_warning = out_warn_reg;
    assign next_mode     = out_mode_reg;

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the wall follow controller core: directed and randomized wall scenes
// are compared against a cycle-free drive command predictor.

import wfc_pkg::*;

typedef logic [NSENS-1:0][SMP_W-1:0] scan_t;

typedef struct packed {
    logic                    drive;
    logic signed [OUT_W-1:0] left_spd;
    logic signed [OUT_W-1:0] right_spd;
    logic                    warning;
    logic [MODE_W-1:0]       mode;
} drive_cmd_t;

class wall_follow_checker;
    logic [SMP_W-1:0]   windows [NSENS][WINDOW];
    int unsigned        slot;
    int unsigned        warm_ticks;
    logic [MODE_W-1:0]  mode;
    logic [THR_W-1:0]   thr [5];
    logic [SCALE_W-1:0] scale;
    logic [LIM_W-1:0]   limit;
    drive_cmd_t         expected_cmds [$];
    int                 errors;
    int                 results_seen;

    function new();
        foreach (windows[s, i]) windows[s][i] = '0;
        slot = 0;
        warm_ticks = 0;
        mode = MODE_OK;
        thr[CFG_NO_WALL] = 150;
        thr[CFG_FAR_OK] = 200;
        thr[CFG_FAR] = 250;
        thr[CFG_CLOSE] = 500;
        thr[CFG_COLLISION] = 1000;
        scale = 1;
        limit = 1000;
        errors = 0;
        results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_NO_WALL, CFG_FAR_OK, CFG_FAR, CFG_CLOSE, CFG_COLLISION: thr[idx] = data;
            CFG_SCALE: scale = data[SCALE_W-1:0];
            CFG_LIMIT: limit = data[LIM_W-1:0];
            default: ;
        endcase
    endfunction

    function drive_cmd_t wheel_cmd(int l, int r);
        drive_cmd_t c;
        int ls, rs, lim;
        ls = l * int'(scale);
        rs = r * int'(scale);
        lim = int'(limit);
        c = '0;
        c.drive = 1'b1;
        if ((ls < 0 ? -ls : ls) > lim || (rs < 0 ? -rs : rs) > lim) begin
            c.warning = 1'b1;
            ls = (l < 0) ? -lim : lim;
            rs = (r < 0) ? -lim : lim;
        end
        c.left_spd = ls[OUT_W-1:0];
        c.right_spd = rs[OUT_W-1:0];
        return c;
    endfunction

    function void take_scan(scan_t scan);
        int unsigned win_sum [NSENS];
        int unsigned nw, fok, far_lim, cls, col;
        logic [MODE_W-1:0] m;
        drive_cmd_t c;
        for (int s = 0; s < NSENS; s++) windows[s][slot] = scan[s];
        slot = (slot + 1) % WINDOW;
        c = '0;
        if (warm_ticks < WARM_TICKS) begin
            warm_ticks++;
            c.mode = mode;
            expected_cmds.push_back(c);
            return;
        end
        for (int s = 0; s < NSENS; s++) begin
            win_sum[s] = 0;
            for (int i = 0; i < WINDOW; i++) win_sum[s] += windows[s][i];
        end
        nw = WINDOW * thr[CFG_NO_WALL];
        fok = WINDOW * thr[CFG_FAR_OK];
        far_lim = WINDOW * thr[CFG_FAR];
        cls = WINDOW * thr[CFG_CLOSE];
        col = WINDOW * thr[CFG_COLLISION];
        m = mode;
        case (mode)
            MODE_OK: begin
                if (win_sum[SENS_RFRONT] > col || win_sum[SENS_LFRONT] > col ||
                    win_sum[SENS_RDIAG] > col || win_sum[SENS_LDIAG] > col)
                    m = MODE_RTURN;
                else if (win_sum[SENS_LDIAG] > cls)
                    m = MODE_CLOSE;
                else if (win_sum[SENS_LDIAG] < far_lim)
                    m = (win_sum[SENS_LDIAG] < nw) ? MODE_LSTART : MODE_FAR;
                else
                    c = wheel_cmd(SPD_FULL, SPD_FULL);
            end
            MODE_FAR: begin
                c = wheel_cmd(SPD_SLOW, SPD_FULL);
                if (win_sum[SENS_LDIAG] > fok) m = MODE_OK;
                else if (win_sum[SENS_LDIAG] < nw) m = MODE_LSTART;
            end
            MODE_CLOSE: begin
                c = wheel_cmd(SPD_FULL, SPD_SLOW);
                if (win_sum[SENS_LDIAG] < cls) m = MODE_OK;
            end
            MODE_LSTART: begin
                c = wheel_cmd(SPD_FULL, SPD_FULL);
                if (win_sum[SENS_LSIDE] < nw) m = MODE_LTURN;
            end
            MODE_LTURN: begin
                c = wheel_cmd(SPD_TURN, SPD_FULL);
                if (win_sum[SENS_LDIAG] > far_lim) m = MODE_OK;
            end
            MODE_RTURN: begin
                c = wheel_cmd(SPD_FULL, SPD_BACK);
                if (win_sum[SENS_LFRONT] < nw && win_sum[SENS_RFRONT] < nw) m = MODE_OK;
            end
            default: c = wheel_cmd(SPD_ZERO, SPD_ZERO);
        endcase
        mode = m;
        c.mode = m;
        expected_cmds.push_back(c);
    endfunction

    task report(string what, int got, int want);
        if (errors < 100)
            $display("MISMATCH %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
        errors++;
    endtask

    task check_cmd(drive_cmd_t got);
        drive_cmd_t want;
        results_seen++;
        if (expected_cmds.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
        end
        want = expected_cmds.pop_front();
        if (got.drive !== want.drive) report("drive_valid", got.drive, want.drive);
        if (got.left_spd !== want.left_spd)
            report("left_speed", int'($signed(got.left_spd)), int'($signed(want.left_spd)));
        if (got.right_spd !== want.right_spd)
            report("right_speed", int'($signed(got.right_spd)), int'($signed(want.right_spd)));
        if (got.warning !== want.warning) report("speed_warning", got.warning, want.warning);
        if (got.mode !== want.mode) report("next_mode", got.mode, want.mode);
    endtask
endclass

module tb;
    localparam int IDLE_LIMIT = 1000;
    localparam int PHASES = 11;
    localparam int PHASE_ITEMS = 130;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [THR_W-1:0] DEF_NO_WALL = 150;
    localparam logic [THR_W-1:0] DEF_FAR_OK = 200;
    localparam logic [THR_W-1:0] DEF_FAR = 250;
    localparam logic [THR_W-1:0] DEF_CLOSE = 500;
    localparam logic [THR_W-1:0] DEF_COLLISION = 1000;
    localparam logic [THR_W-1:0] THR_MAX = 4095;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [SMP_W-1:0]        s_right_front_sample;
    logic [SMP_W-1:0]        s_right_diag_sample;
    logic [SMP_W-1:0]        s_left_side_sample;
    logic [SMP_W-1:0]        s_left_diag_sample;
    logic [SMP_W-1:0]        s_left_front_sample;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_drive_valid;
    logic signed [OUT_W-1:0] m_left_speed;
    logic signed [OUT_W-1:0] m_right_speed;
    logic                    m_speed_warning;
    logic [MODE_W-1:0]       m_next_mode;

    wall_follow_checker cmd_chk;
    int burst_left = 0;
    int idle_cycles = 0;
    logic [15:0] ready_pat = 16'hFFFF;
    logic [5:0]  ready_tick = '0;

    wall_follow_controller_core dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_right_front_sample (s_right_front_sample),
        .s_right_diag_sample  (s_right_diag_sample),
        .s_left_side_sample   (s_left_side_sample),
        .s_left_diag_sample   (s_left_diag_sample),
        .s_left_front_sample  (s_left_front_sample),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_drive_valid        (m_drive_valid),
        .m_left_speed         (m_left_speed),
        .m_right_speed        (m_right_speed),
        .m_speed_warning      (m_speed_warning),
        .m_next_mode          (m_next_mode)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver stall pattern, reloaded each time the tick counter wraps.
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1'b1;
        if (ready_tick == '0)
            ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
        m_ready <= ready_pat[ready_tick[3:0]];
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            cmd_chk.check_cmd({m_drive_valid, m_left_speed, m_right_speed,
                               m_speed_warning, m_next_mode});
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [SMP_W-1:0] clip(int v);
        return (v < 0) ? '0 : (v > 4095) ? THR_MAX : v[SMP_W-1:0];
    endfunction

    // Levels cluster around the live thresholds so the mode machine gets exercised.
    function automatic logic [SMP_W-1:0] pick_level(bit fore);
        int r;
        r = $urandom_range(0, 9);
        if (fore && r < 5) return SMP_W'($urandom_range(0, cmd_chk.thr[CFG_NO_WALL]));
        if (r == 9) return SMP_W'($urandom_range(0, 4095));
        return clip(int'(cmd_chk.thr[$urandom_range(CFG_NO_WALL, CFG_COLLISION)])
                    + int'($urandom_range(0, 60)) - 30);
    endfunction

    task automatic send_scan(scan_t scan);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_right_front_sample <= scan[SENS_RFRONT];
        s_right_diag_sample <= scan[SENS_RDIAG];
        s_left_side_sample <= scan[SENS_LSIDE];
        s_left_diag_sample <= scan[SENS_LDIAG];
        s_left_front_sample <= scan[SENS_LFRONT];
        do @(posedge aclk); while (!s_ready);
        cmd_chk.take_scan(scan);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cmd_chk.set_reg(idx, data);
    endtask

    task automatic configure(logic [THR_W-1:0] nw, logic [THR_W-1:0] fok,
                             logic [THR_W-1:0] far_t, logic [THR_W-1:0] cls,
                             logic [THR_W-1:0] col, logic [SCALE_W-1:0] scl,
                             logic [LIM_W-1:0] lim, bit poke_unused);
        write_reg(CFG_NO_WALL, nw);
        write_reg(CFG_FAR_OK, fok);
        write_reg(CFG_FAR, far_t);
        write_reg(CFG_CLOSE, cls);
        write_reg(CFG_COLLISION, col);
        write_reg(CFG_SCALE, {8'($urandom()), scl});
        write_reg(CFG_LIMIT, {2'($urandom()), lim});
        if (poke_unused) write_reg(CFG_UNUSED, 12'($urandom()));
        cfg_we <= 1'b0;
    endtask

    task automatic finish_phase();
        s_valid <= 1'b0;
        while (cmd_chk.expected_cmds.size() != 0) @(posedge aclk);
    endtask

    task automatic directed_scans();
        scan_t scan;
        // Warmup with all-zero, all-one and alternating bit patterns.
        for (int i = 0; i < WARM_TICKS; i++) begin
            for (int s = 0; s < NSENS; s++)
                case ((i + s) % 4)
                    0: scan[s] = 12'h000;
                    1: scan[s] = 12'hFFF;
                    2: scan[s] = 12'hAAA;
                    default: scan[s] = 12'h555;
                endcase
            send_scan(scan);
        end
        repeat (5) send_scan({NSENS{12'hFFF}});
        repeat (5) send_scan('0);
        scan = '0;
        scan[SENS_LDIAG] = 600;
        scan[SENS_LSIDE] = 600;
        repeat (5) send_scan(scan);
    endtask

    task automatic roam(int n_items);
        scan_t base, scan;
        int hold, sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 6) == 0) begin
                for (int s = 0; s < NSENS; s++) scan[s] = SMP_W'($urandom_range(0, 4095));
                send_scan(scan);
                sent++;
            end else begin
                for (int s = 0; s < NSENS; s++)
                    base[s] = pick_level(s == SENS_RFRONT || s == SENS_LFRONT ||
                                         s == SENS_RDIAG);
                hold = $urandom_range(1, 12);
                repeat (hold) begin
                    for (int s = 0; s < NSENS; s++)
                        scan[s] = clip(int'(base[s]) + int'($urandom_range(0, 8)) - 4);
                    send_scan(scan);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_right_front_sample = '0;
        s_right_diag_sample = '0;
        s_left_side_sample = '0;
        s_left_diag_sample = '0;
        s_left_front_sample = '0;
        cmd_chk = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        configure(DEF_NO_WALL, DEF_FAR_OK, DEF_FAR, DEF_CLOSE, DEF_COLLISION, 1, 1000, 0);
        directed_scans();
        roam(PHASE_ITEMS);
        finish_phase();
        for (int p = 1; p < PHASES; p++) begin
            case (p)
                1: configure(DEF_NO_WALL, DEF_FAR_OK, DEF_FAR, DEF_CLOSE, DEF_COLLISION,
                             10, 1000, 0);
                2: configure(DEF_NO_WALL, DEF_FAR_OK, DEF_FAR, DEF_CLOSE, DEF_COLLISION,
                             15, 1023, 0);
                3: configure('0, '0, '0, '0, '0, 0, 0, 0);
                4: configure(THR_MAX, THR_MAX, THR_MAX, THR_MAX, THR_MAX, 1, 0, 0);
                5: configure(DEF_NO_WALL, DEF_FAR_OK, DEF_FAR, DEF_CLOSE, DEF_COLLISION,
                             3, 1, 1);
                default: configure(THR_W'($urandom_range(0, 4095)),
                                   THR_W'($urandom_range(0, 4095)),
                                   THR_W'($urandom_range(0, 4095)),
                                   THR_W'($urandom_range(0, 4095)),
                                   THR_W'($urandom_range(0, 4095)),
                                   SCALE_W'($urandom_range(0, 15)),
                                   LIM_W'($urandom_range(0, 1023)), 0);
            endcase
            roam(PHASE_ITEMS);
            finish_phase();
        end
        repeat (20) @(posedge aclk);
        if (cmd_chk.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
